>>> rtl/mmp_pkg.sv
package mmp_pkg;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_RX    = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_VERDICT = 2'd1,
        KIND_REPORT  = 2'd2
    } t_kind;

    // Frame verdicts.
    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_HEADER = 2'd1,
        VERDICT_CRC    = 2'd2,
        VERDICT_RANGE  = 2'd3
    } t_verdict;

    // Jobs passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_REQ     = 2'd0,
        OP_VERDICT = 2'd1,
        OP_TICK    = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    // Back end sequencer states.
    typedef enum logic {
        BK_RUN  = 1'b0,
        BK_SEND = 1'b1
    } t_back_state;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT   = 2'd1;

    localparam logic [7:0]  METER_ADDRESS_RST = 8'd1;
    localparam logic [15:0] STALE_LIMIT_RST   = 16'd3000;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_INPUT  = 8'h04;
    localparam logic [7:0] REQ_REG_COUNT    = 8'h03;
    localparam logic [7:0] REPLY_BYTE_COUNT = 8'h06;
    localparam logic [6:0] PERCENT_MAX      = 7'd100;

    localparam int REQ_LEN  = 8;
    localparam int REQ_IDX_W = $clog2(REQ_LEN);
    localparam int DATA_LEN = 6;
    localparam int DATA_IDX_W = $clog2(DATA_LEN);

    // Reply byte positions.
    localparam logic [3:0] RX_ADDR    = 4'd0;
    localparam logic [3:0] RX_FUNC    = 4'd1;
    localparam logic [3:0] RX_COUNT   = 4'd2;
    localparam logic [3:0] RX_DATA0   = 4'd3;
    localparam logic [3:0] RX_CRC_LO  = 4'd9;
    localparam logic [3:0] RX_CRC_HI  = 4'd10;

    // Job queue depth.
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  verdict;
        logic [6:0]  percent;
        logic [15:0] voltage_centi_volts;
        logic        alarm;
        logic        fresh;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        t_verdict    verdict;
        logic [6:0]  percent;
        logic [15:0] voltage;
        logic        alarm;
    } t_job;

    // One byte of the reflected CRC-16 update.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/mmp_front.sv
module mmp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  mmp_pkg::t_in_item i_item,
    input  logic [7:0]       i_meter_address,
    output logic             o_job_valid,
    output mmp_pkg::t_job    o_job
);

    logic        r_receiving, n_receiving;
    logic [3:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic        r_hdr_ok, n_hdr_ok;
    logic [7:0]  r_crc_low, n_crc_low;
    logic [7:0]  r_data [mmp_pkg::DATA_LEN];

    logic                          w_data_we;
    logic [mmp_pkg::DATA_IDX_W-1:0] w_data_idx;
    logic [3:0]                    w_data_off;
    logic [15:0]                   w_pct_word;
    logic [15:0]                   w_volt_word;
    logic [15:0]                   w_alm_word;
    mmp_pkg::t_verdict             w_verdict;

    assign w_data_off  = r_count - mmp_pkg::RX_DATA0;
    assign w_data_idx  = w_data_off[mmp_pkg::DATA_IDX_W-1:0];
    assign w_pct_word  = {r_data[0], r_data[1]};
    assign w_volt_word = {r_data[2], r_data[3]};
    assign w_alm_word  = {r_data[4], r_data[5]};

    // Verdict of a completed frame; header faults outrank CRC faults,
    // which outrank range faults.
    always_comb begin
        if (!r_hdr_ok) begin
            w_verdict = mmp_pkg::VERDICT_HEADER;
        end else if (r_crc_low != r_crc[7:0] || i_item.rx_byte != r_crc[15:8]) begin
            w_verdict = mmp_pkg::VERDICT_CRC;
        end else if (w_pct_word > {9'd0, mmp_pkg::PERCENT_MAX} || w_volt_word == 16'd0
                     || w_alm_word > 16'd1) begin
            w_verdict = mmp_pkg::VERDICT_RANGE;
        end else begin
            w_verdict = mmp_pkg::VERDICT_OK;
        end
    end

    always_comb begin
        n_receiving = r_receiving;
        n_count     = r_count;
        n_crc       = r_crc;
        n_hdr_ok    = r_hdr_ok;
        n_crc_low   = r_crc_low;
        w_data_we   = 1'b0;
        o_job_valid = 1'b0;
        o_job.op      = mmp_pkg::OP_TICK;
        o_job.verdict = w_verdict;
        o_job.percent = w_pct_word[6:0];
        o_job.voltage = w_volt_word;
        o_job.alarm   = w_alm_word[0];
        if (i_accept) begin
            case (mmp_pkg::t_cmd'(i_item.command))
                mmp_pkg::CMD_START: begin
                    o_job_valid = 1'b1;
                    o_job.op    = mmp_pkg::OP_REQ;
                    n_receiving = 1'b1;
                    n_count     = mmp_pkg::RX_ADDR;
                    n_crc       = mmp_pkg::CRC_INIT;
                    n_hdr_ok    = 1'b1;
                    n_crc_low   = 8'd0;
                end
                mmp_pkg::CMD_RX: begin
                    if (r_receiving) begin
                        if (r_count < mmp_pkg::RX_CRC_LO) begin
                            n_crc   = mmp_pkg::crc_feed(r_crc, i_item.rx_byte);
                            n_count = r_count + 4'd1;
                            if (r_count == mmp_pkg::RX_ADDR
                                && i_item.rx_byte != i_meter_address) begin
                                n_hdr_ok = 1'b0;
                            end
                            if (r_count == mmp_pkg::RX_FUNC
                                && i_item.rx_byte != mmp_pkg::FUNC_READ_INPUT) begin
                                n_hdr_ok = 1'b0;
                            end
                            if (r_count == mmp_pkg::RX_COUNT
                                && i_item.rx_byte != mmp_pkg::REPLY_BYTE_COUNT) begin
                                n_hdr_ok = 1'b0;
                            end
                            w_data_we = (r_count >= mmp_pkg::RX_DATA0);
                        end else if (r_count == mmp_pkg::RX_CRC_LO) begin
                            n_crc_low = i_item.rx_byte;
                            n_count   = mmp_pkg::RX_CRC_HI;
                        end else begin
                            o_job_valid = 1'b1;
                            o_job.op    = mmp_pkg::OP_VERDICT;
                            n_receiving = 1'b0;
                            n_count     = mmp_pkg::RX_ADDR;
                        end
                    end
                end
                mmp_pkg::CMD_TICK: begin
                    o_job_valid = 1'b1;
                    o_job.op    = mmp_pkg::OP_TICK;
                end
                default: begin
                    o_job_valid = 1'b1;
                    o_job.op    = mmp_pkg::OP_QUERY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_count     <= mmp_pkg::RX_ADDR;
            r_crc       <= mmp_pkg::CRC_INIT;
            r_hdr_ok    <= 1'b1;
            r_crc_low   <= 8'd0;
        end else begin
            r_receiving <= n_receiving;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_hdr_ok    <= n_hdr_ok;
            r_crc_low   <= n_crc_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            r_data[w_data_idx] <= i_item.rx_byte;
        end
    end

endmodule

>>> rtl/mmp_fifo.sv
module mmp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mmp_pkg::t_job i_job,
    input  logic          i_pop,
    output mmp_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    mmp_pkg::t_job r_mem [mmp_pkg::JOB_DEPTH];
    logic [mmp_pkg::JOB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mmp_pkg::JOB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mmp_pkg::JOB_PTR_W:0]   r_fill, n_fill;

    assign o_full  = (r_fill == (mmp_pkg::JOB_PTR_W+1)'(mmp_pkg::JOB_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_fill   = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> rtl/mmp_back.sv
module mmp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_meter_address,
    input  logic [15:0]       i_stale_limit,
    input  logic              i_job_empty,
    input  mmp_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mmp_pkg::t_out_item o_out_data
);

    mmp_pkg::t_back_state r_state, n_state;
    logic [mmp_pkg::REQ_IDX_W-1:0] r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_age, n_age;
    logic [6:0]  r_pct, n_pct;
    logic [15:0] r_volt, n_volt;
    logic        r_alarm, n_alarm;
    logic        r_held, n_held;
    logic        r_out_valid, n_out_valid;
    mmp_pkg::t_out_item r_out, n_out;

    logic       w_out_free;
    logic [7:0] w_req_byte;

    localparam logic [mmp_pkg::REQ_IDX_W-1:0] IDX_CRC_LO = mmp_pkg::REQ_IDX_W'(mmp_pkg::REQ_LEN - 2);
    localparam logic [mmp_pkg::REQ_IDX_W-1:0] IDX_LAST = mmp_pkg::REQ_IDX_W'(mmp_pkg::REQ_LEN - 1);

    function automatic mmp_pkg::t_out_item make_report(
        input mmp_pkg::t_kind kind, input mmp_pkg::t_verdict verdict,
        input logic [6:0] pct, input logic [15:0] volt, input logic alm, input logic fresh);
        mmp_pkg::t_out_item r;
        r.kind                = kind;
        r.tx_byte             = 8'd0;
        r.last                = 1'b1;
        r.verdict             = verdict;
        r.percent             = pct;
        r.voltage_centi_volts = volt;
        r.alarm               = alm;
        r.fresh               = fresh;
        return r;
    endfunction

    function automatic mmp_pkg::t_out_item make_tx(input logic [7:0] b, input logic last);
        mmp_pkg::t_out_item r;
        r         = '0;
        r.kind    = mmp_pkg::KIND_TX;
        r.tx_byte = b;
        r.last    = last;
        return r;
    endfunction

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Request bytes after the address; the CRC follows the fixed part.
    always_comb begin
        case (r_idx)
            3'd1:    w_req_byte = mmp_pkg::FUNC_READ_INPUT;
            3'd5:    w_req_byte = mmp_pkg::REQ_REG_COUNT;
            3'd6:    w_req_byte = r_crc[7:0];
            3'd7:    w_req_byte = r_crc[15:8];
            default: w_req_byte = 8'd0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmp_pkg::BK_RUN: begin
                if (!i_job_empty && i_job.op == mmp_pkg::OP_REQ && w_out_free) begin
                    n_state = mmp_pkg::BK_SEND;
                end
            end
            mmp_pkg::BK_SEND: begin
                if (w_out_free && r_idx == IDX_LAST) begin
                    n_state = mmp_pkg::BK_RUN;
                end
            end
            default: n_state = mmp_pkg::BK_RUN;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        o_pop       = 1'b0;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_age       = r_age;
        n_pct       = r_pct;
        n_volt      = r_volt;
        n_alarm     = r_alarm;
        n_held      = r_held;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            mmp_pkg::BK_RUN: begin
                if (!i_job_empty) begin
                    case (i_job.op)
                        mmp_pkg::OP_TICK: begin
                            o_pop = 1'b1;
                            if (r_age != 16'hFFFF) begin
                                n_age = r_age + 16'd1;
                            end
                        end
                        mmp_pkg::OP_QUERY: begin
                            if (w_out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out = make_report(mmp_pkg::KIND_REPORT, mmp_pkg::VERDICT_OK,
                                    r_pct, r_volt, r_alarm, r_held && (r_age <= i_stale_limit));
                            end
                        end
                        mmp_pkg::OP_VERDICT: begin
                            if (w_out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                if (i_job.verdict == mmp_pkg::VERDICT_OK) begin
                                    n_pct   = i_job.percent;
                                    n_volt  = i_job.voltage;
                                    n_alarm = i_job.alarm;
                                    n_held  = 1'b1;
                                    n_age   = 16'd0;
                                end
                                n_out = make_report(mmp_pkg::KIND_VERDICT, i_job.verdict,
                                    n_pct, n_volt, n_alarm, n_held && (n_age <= i_stale_limit));
                            end
                        end
                        default: begin
                            if (w_out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = make_tx(i_meter_address, 1'b0);
                                n_crc       = mmp_pkg::crc_feed(mmp_pkg::CRC_INIT,
                                                                i_meter_address);
                                n_idx       = mmp_pkg::REQ_IDX_W'(1);
                            end
                        end
                    endcase
                end
            end
            mmp_pkg::BK_SEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = make_tx(w_req_byte, r_idx == IDX_LAST);
                    n_idx       = r_idx + 1'b1;
                    if (r_idx < IDX_CRC_LO) begin
                        n_crc = mmp_pkg::crc_feed(r_crc, w_req_byte);
                    end
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmp_pkg::BK_RUN;
            r_idx       <= '0;
            r_age       <= 16'd0;
            r_pct       <= 7'd0;
            r_volt      <= 16'd0;
            r_alarm     <= 1'b0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_age       <= n_age;
            r_pct       <= n_pct;
            r_volt      <= n_volt;
            r_alarm     <= n_alarm;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_out <= n_out;
    end

endmodule

>>> rtl/modbus_meter_poll_and_reply_check.sv
// When the queue is empty and the output is free, an accepted request's result passes through
// the job queue and then the output register before it appears at the output.
// Throughput: one request per cycle unless the job queue is full; a start command holds the
// back end while it sends the eight request bytes; the four-entry queue absorbs requests.
// Reset: synchronous, active low; it clears the reply tracker, the held sample, the queue
// and the output register, and sets the address to 1 and the stale limit to 3000 ticks.
module modbus_meter_poll_and_reply_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mmp_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mmp_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    // Configuration registers. Writes are accepted in every cycle; an index
    // beyond the register list is ignored.
    logic [7:0]  r_meter_address;
    logic [15:0] r_stale_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meter_address <= mmp_pkg::METER_ADDRESS_RST;
            r_stale_limit   <= mmp_pkg::STALE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mmp_pkg::CFG_METER_ADDRESS) begin
                r_meter_address <= i_cfg_data[7:0];
            end
            if (i_cfg_index == mmp_pkg::CFG_STALE_LIMIT) begin
                r_stale_limit <= i_cfg_data;
            end
        end
    end

    // The front end tracks the reply frame and turns every request that
    // needs later work into a job. It stalls only when the job queue is full.
    logic          w_accept;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    mmp_pkg::t_job w_front_job;
    mmp_pkg::t_job w_head_job;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    mmp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_item          (i_in_data),
        .i_meter_address (r_meter_address),
        .o_job_valid     (w_push),
        .o_job           (w_front_job)
    );

    // The job queue decouples the byte-by-byte reply checking from the
    // result emission, so a slow consumer does not stall the receiver
    // until the queue fills.
    mmp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // The back end owns the held sample and its age, emits the request
    // frame one byte per cycle while the output is free, with a running
    // CRC, and drives the output register. Ticks are applied in queue
    // order so reports always see the age that the input order implies.
    mmp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_meter_address (r_meter_address),
        .i_stale_limit   (r_stale_limit),
        .i_job_empty     (w_empty),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

    // The front end never pushes a job into a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_push |-> !w_full)
        else $error("job pushed into a full queue");

    // The back end never pops an empty queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

    // An accepted frame has just latched a sample, so it must report fresh.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == mmp_pkg::KIND_VERDICT
         && o_out_data.verdict == mmp_pkg::VERDICT_OK) |-> o_out_data.fresh)
        else $error("accepted frame reported as stale");

endmodule
